### design/pbcq_pkg.sv
// Shared types and constants for the paced bit change queues block.
package pbcq_pkg;

  // Fixed field widths of the item and result words.
  localparam int MODE_W      = 2;
  localparam int CH_IDX_W    = 4;
  localparam int TIME_W      = 32;
  localparam int RX_CH_W     = 8;
  localparam int WORD_W      = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [TIME_W-1:0] RELEASE_DELAY_RESET = 32'd100;
  localparam logic [WORD_W-1:0] LISTEN_MASK_RESET   = 16'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_RX    = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RELEASE_DELAY = 1'b0,
    REG_LISTEN_MASK   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;   // Execute the accepted word and load the result register.
  } ctrl_cmd_t;

  // Status from the controller, visible at the top level.
  typedef struct packed {
    logic in_stall;
    logic out_valid;
  } ctrl_status_t;

endpackage

### design/pbcq_ctrl.sv
// Controller: tracks whether the result register holds an undelivered word.
module pbcq_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    out_stall,
  output pbcq_pkg::ctrl_cmd_t     cmd,
  output pbcq_pkg::ctrl_status_t  status
);

  pbcq_pkg::ctrl_state_t state, state_next;
  logic                  exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbcq_pkg::ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // A new word may enter whenever the result register is empty or is
  // being taken in this same cycle.
  always_comb begin
    status.out_valid = (state == pbcq_pkg::ST_FULL);
    status.in_stall  = (state == pbcq_pkg::ST_FULL) && out_stall;
    exec             = in_valid && !status.in_stall;
    cmd.exec         = exec;
  end

  always_comb begin
    state_next = state;
    case (state)
      pbcq_pkg::ST_EMPTY: begin
        if (exec) state_next = pbcq_pkg::ST_FULL;
      end
      pbcq_pkg::ST_FULL: begin
        if (!out_stall && !exec) state_next = pbcq_pkg::ST_EMPTY;
      end
      default: state_next = pbcq_pkg::ST_EMPTY;
    endcase
  end

endmodule

### design/pbcq_datapath.sv
// Datapath: per-channel level queues, release timers, word state and result register.
module pbcq_datapath #(
  parameter int CHANNELS    = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pbcq_pkg::ctrl_cmd_t                  cmd,
  input  logic                                 cfg_write,
  input  logic [pbcq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pbcq_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [pbcq_pkg::MODE_W-1:0]          mode,
  input  logic [pbcq_pkg::CH_IDX_W-1:0]        channel_index,
  input  logic                                 push_level,
  input  logic [pbcq_pkg::TIME_W-1:0]          now_ms,
  input  logic [pbcq_pkg::RX_CH_W-1:0]         rx_channel,
  input  logic [pbcq_pkg::WORD_W-1:0]          rx_value,
  output logic                                 send_valid,
  output logic [pbcq_pkg::WORD_W-1:0]          send_word,
  output logic                                 push_accepted,
  output logic [pbcq_pkg::WORD_W-1:0]          rx_changed,
  output logic [pbcq_pkg::WORD_W-1:0]          rx_levels
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [QUEUE_DEPTH-1:0]          levels [CHANNELS];
  logic [QUEUE_DEPTH-1:0]          levels_next [CHANNELS];
  logic [CNT_W-1:0]                count [CHANNELS];
  logic [CNT_W-1:0]                count_next [CHANNELS];
  logic [pbcq_pkg::TIME_W-1:0]     last_time [CHANNELS];
  logic [pbcq_pkg::TIME_W-1:0]     last_time_next [CHANNELS];
  logic [CHANNELS-1:0]             out_bits, out_bits_next;
  logic [pbcq_pkg::WORD_W-1:0]     in_bits, in_bits_next;
  logic [pbcq_pkg::TIME_W-1:0]     release_delay;
  logic [pbcq_pkg::WORD_W-1:0]     listen_mask;
  logic                            accepted_next;
  logic [pbcq_pkg::WORD_W-1:0]     changed_next;
  logic [pbcq_pkg::WORD_W-1:0]     word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_delay <= pbcq_pkg::RELEASE_DELAY_RESET;
      listen_mask   <= pbcq_pkg::LISTEN_MASK_RESET;
    end else if (cfg_write) begin
      case (pbcq_pkg::cfg_reg_t'(cfg_index))
        pbcq_pkg::REG_RELEASE_DELAY: release_delay <= cfg_data;
        pbcq_pkg::REG_LISTEN_MASK:   listen_mask   <= cfg_data[pbcq_pkg::WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                        last_lvl;
    logic [pbcq_pkg::TIME_W-1:0] elapsed;
    last_lvl      = 1'b0;
    elapsed       = '0;
    levels_next    = levels;
    count_next     = count;
    last_time_next = last_time;
    out_bits_next  = out_bits;
    in_bits_next   = in_bits;
    accepted_next  = 1'b0;
    changed_next   = '0;
    case (pbcq_pkg::mode_t'(mode))
      pbcq_pkg::MODE_PUSH: begin
        // A channel index at or beyond CHANNELS matches no channel.
        for (int c = 0; c < CHANNELS; c++) begin
          if (32'(channel_index) == c) begin
            last_lvl = out_bits[c];
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
              if (count[c] == CNT_W'(k + 1)) last_lvl = levels[c][k];
            end
            if (count[c] != CNT_W'(QUEUE_DEPTH) && push_level != last_lvl) begin
              for (int k = 0; k < QUEUE_DEPTH; k++) begin
                if (count[c] == CNT_W'(k)) levels_next[c][k] = push_level;
              end
              count_next[c] = count[c] + 1'b1;
              accepted_next = 1'b1;
            end
          end
        end
      end
      pbcq_pkg::MODE_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          elapsed = now_ms - last_time[c];
          if (count[c] != '0 && elapsed > release_delay) begin
            levels_next[c]    = levels[c] >> 1;
            count_next[c]     = count[c] - 1'b1;
            out_bits_next[c]  = levels[c][0];
            last_time_next[c] = now_ms;
          end
        end
      end
      pbcq_pkg::MODE_RX: begin
        if (rx_channel == '0) begin
          changed_next = (in_bits ^ rx_value) & listen_mask;
          in_bits_next = rx_value;
        end
      end
      pbcq_pkg::MODE_CLEAR: begin
        for (int c = 0; c < CHANNELS; c++) begin
          levels_next[c] = '0;
          count_next[c]  = '0;
        end
      end
      default: ;
    endcase
  end

  // Only the low sixteen output bits are visible in the sent word.
  generate
    if (CHANNELS >= pbcq_pkg::WORD_W) begin : g_word_cut
      assign word_next = out_bits_next[pbcq_pkg::WORD_W-1:0];
    end else begin : g_word_ext
      assign word_next = {{(pbcq_pkg::WORD_W - CHANNELS){1'b0}}, out_bits_next};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        levels[c]    <= '0;
        count[c]     <= '0;
        last_time[c] <= '0;
      end
      out_bits <= '0;
      in_bits  <= '0;
    end else if (cmd.exec) begin
      levels    <= levels_next;
      count     <= count_next;
      last_time <= last_time_next;
      out_bits  <= out_bits_next;
      in_bits   <= in_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_valid    <= 1'b0;
      send_word     <= '0;
      push_accepted <= 1'b0;
      rx_changed    <= '0;
      rx_levels     <= '0;
    end else if (cmd.exec) begin
      send_valid    <= (out_bits_next != out_bits);
      send_word     <= word_next;
      push_accepted <= accepted_next;
      rx_changed    <= changed_next;
      rx_levels     <= in_bits_next;
    end
  end

endmodule

### design/paced_bit_change_queues_core.sv
// Top level of the paced bit change queues block: controller and datapath.
// A result word appears on the output in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output side takes results; the single
// result register sets that figure, and every channel's queue and timer compare runs in parallel.
// Reset (rst, synchronous): queues, counts, release times and both bit words clear to zero,
// release_delay returns to 100 and listen_mask to 0.
module paced_bit_change_queues_core #(
  parameter int CHANNELS    = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pbcq_pkg::MODE_W-1:0]          mode,
  input  logic [pbcq_pkg::CH_IDX_W-1:0]        channel_index,
  input  logic                                 push_level,
  input  logic [pbcq_pkg::TIME_W-1:0]          now_ms,
  input  logic [pbcq_pkg::RX_CH_W-1:0]         rx_channel,
  input  logic [pbcq_pkg::WORD_W-1:0]          rx_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 send_valid,
  output logic [pbcq_pkg::WORD_W-1:0]          send_word,
  output logic                                 push_accepted,
  output logic [pbcq_pkg::WORD_W-1:0]          rx_changed,
  output logic [pbcq_pkg::WORD_W-1:0]          rx_levels,
  input  logic                                 cfg_write,
  input  logic [pbcq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pbcq_pkg::CFG_DATA_W-1:0]      cfg_data
);

  pbcq_pkg::ctrl_cmd_t    cmd;
  pbcq_pkg::ctrl_status_t status;

  pbcq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  pbcq_datapath #(
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .channel_index (channel_index),
    .push_level    (push_level),
    .now_ms        (now_ms),
    .rx_channel    (rx_channel),
    .rx_value      (rx_value),
    .send_valid    (send_valid),
    .send_word     (send_word),
    .push_accepted (push_accepted),
    .rx_changed    (rx_changed),
    .rx_levels     (rx_levels)
  );

  assign in_stall  = status.in_stall;
  assign out_valid = status.out_valid;

`ifndef SYNTHESIS
  // The input side is only held back by a waiting result word.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result word waiting");

  // Every accepted word yields a result word in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word produced no result");

  // A push result never reports a send or a receive change.
  a_push_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && push_accepted) |-> (!send_valid && rx_changed == '0))
    else $error("push result carries tick or receive flags");

  // The sent word changes only when a new word has been executed.
  a_word_stable: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall) |=> $stable(send_word))
    else $error("send_word changed without an accepted word");
`endif

endmodule

### bench/pbcq_checker.sv
// Checker for the paced bit change queues block: predicts every result word and compares it.
`timescale 1ns / 1ps
module pbcq_checker #(
  parameter int CHANNELS    = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [pbcq_pkg::MODE_W-1:0]          mode,
  input  logic [pbcq_pkg::CH_IDX_W-1:0]        channel_index,
  input  logic                                 push_level,
  input  logic [pbcq_pkg::TIME_W-1:0]          now_ms,
  input  logic [pbcq_pkg::RX_CH_W-1:0]         rx_channel,
  input  logic [pbcq_pkg::WORD_W-1:0]          rx_value,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 send_valid,
  input  logic [pbcq_pkg::WORD_W-1:0]          send_word,
  input  logic                                 push_accepted,
  input  logic [pbcq_pkg::WORD_W-1:0]          rx_changed,
  input  logic [pbcq_pkg::WORD_W-1:0]          rx_levels,
  input  logic                                 cfg_write,
  input  logic [pbcq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pbcq_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatches,
  output int                                   waiting
);

  localparam int WORD_W   = pbcq_pkg::WORD_W;
  localparam int TIME_W   = pbcq_pkg::TIME_W;
  localparam int CH_IDX_W = pbcq_pkg::CH_IDX_W;
  localparam int RX_CH_W  = pbcq_pkg::RX_CH_W;

  typedef struct packed {
    logic              send_valid;
    logic [WORD_W-1:0] send_word;
    logic              push_accepted;
    logic [WORD_W-1:0] rx_changed;
    logic [WORD_W-1:0] rx_levels;
  } status_word_t;

  status_word_t expected_words[$];

  // Shadow copy of the block's queues, timers, bit words and registers.
  logic [QUEUE_DEPTH-1:0] queued_levels [CHANNELS];
  int                     queued_count  [CHANNELS];
  logic [TIME_W-1:0]      released_at   [CHANNELS];
  logic [CHANNELS-1:0]    out_bits;
  logic [WORD_W-1:0]      in_bits;
  logic [TIME_W-1:0]      delay_ms;
  logic [WORD_W-1:0]      rx_mask;

  function automatic status_word_t apply_command(pbcq_pkg::mode_t m,
                                                 logic [CH_IDX_W-1:0] ch,
                                                 logic lvl, logic [TIME_W-1:0] now,
                                                 logic [RX_CH_W-1:0] rxch,
                                                 logic [WORD_W-1:0] rxv);
    status_word_t r;
    logic [CHANNELS-1:0] next;
    int n;
    r = '0;
    case (m)
      pbcq_pkg::MODE_PUSH: begin
        if (ch < CHANNELS) begin
          n = queued_count[ch];
          // A level equal to the one it would follow is a no-op and is dropped.
          if (n < QUEUE_DEPTH &&
              ((n > 0) ? (queued_levels[ch][n-1] != lvl) : (out_bits[ch] != lvl))) begin
            queued_levels[ch][n] = lvl;
            queued_count[ch] = n + 1;
            r.push_accepted = 1'b1;
          end
        end
      end
      pbcq_pkg::MODE_TICK: begin
        next = out_bits;
        for (int c = 0; c < CHANNELS; c++) begin
          if (queued_count[c] > 0 && TIME_W'(now - released_at[c]) > delay_ms) begin
            next[c] = queued_levels[c][0];
            queued_levels[c] = queued_levels[c] >> 1;
            queued_count[c] = queued_count[c] - 1;
            released_at[c] = now;
          end
        end
        r.send_valid = (next != out_bits);
        out_bits = next;
      end
      pbcq_pkg::MODE_RX: begin
        if (rxch == '0) begin
          r.rx_changed = (in_bits ^ rxv) & rx_mask;
          in_bits = rxv;
        end
      end
      default: begin
        for (int c = 0; c < CHANNELS; c++) begin
          queued_levels[c] = '0;
          queued_count[c] = 0;
        end
      end
    endcase
    r.send_word = out_bits[WORD_W-1:0];
    r.rx_levels = in_bits;
    return r;
  endfunction

  always @(posedge clk) begin
    status_word_t got;
    status_word_t want;
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        queued_levels[c] = '0;
        queued_count[c] = 0;
        released_at[c] = '0;
      end
      out_bits = '0;
      in_bits = '0;
      delay_ms = pbcq_pkg::RELEASE_DELAY_RESET;
      rx_mask = pbcq_pkg::LISTEN_MASK_RESET;
      expected_words.delete();
      mismatches <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.send_valid = send_valid;
        got.send_word = send_word;
        got.push_accepted = push_accepted;
        got.rx_changed = rx_changed;
        got.rx_levels = rx_levels;
        if (expected_words.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word sv=%0b word=%h acc=%0b chg=%h lvl=%h", $realtime,
                     got.send_valid, got.send_word, got.push_accepted, got.rx_changed,
                     got.rx_levels);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch expected sv=%0b word=%h acc=%0b chg=%h lvl=%h",
                       $realtime, want.send_valid, want.send_word, want.push_accepted,
                       want.rx_changed, want.rx_levels);
              $display("%0t:               got sv=%0b word=%h acc=%0b chg=%h lvl=%h",
                       $realtime, got.send_valid, got.send_word, got.push_accepted,
                       got.rx_changed, got.rx_levels);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg_write) begin
        case (pbcq_pkg::cfg_reg_t'(cfg_index))
          pbcq_pkg::REG_RELEASE_DELAY: delay_ms = cfg_data[TIME_W-1:0];
          pbcq_pkg::REG_LISTEN_MASK:   rx_mask = cfg_data[WORD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_words.push_back(apply_command(pbcq_pkg::mode_t'(mode), channel_index,
                                               push_level, now_ms, rx_channel, rx_value));
    end
    waiting <= expected_words.size();
  end

endmodule

### bench/tb_paced_bit_change_queues_core.sv
// Testbench top for the paced bit change queues block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_paced_bit_change_queues_core;

  localparam int MODE_W      = pbcq_pkg::MODE_W;
  localparam int CH_IDX_W    = pbcq_pkg::CH_IDX_W;
  localparam int TIME_W      = pbcq_pkg::TIME_W;
  localparam int RX_CH_W     = pbcq_pkg::RX_CH_W;
  localparam int WORD_W      = pbcq_pkg::WORD_W;
  localparam int CFG_INDEX_W = pbcq_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = pbcq_pkg::CFG_DATA_W;

  localparam int HOLD_CYCLES    = 200;
  localparam int IDLE_LIMIT     = 3000;
  localparam int ITEMS_PER_PASS = 180;
  localparam int PASSES         = 6;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [MODE_W-1:0]      mode = '0;
  logic [CH_IDX_W-1:0]    channel_index = '0;
  logic                   push_level = 1'b0;
  logic [TIME_W-1:0]      now_ms = '0;
  logic [RX_CH_W-1:0]     rx_channel = '0;
  logic [WORD_W-1:0]      rx_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   send_valid;
  logic [WORD_W-1:0]      send_word;
  logic                   push_accepted;
  logic [WORD_W-1:0]      rx_changed;
  logic [WORD_W-1:0]      rx_levels;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int waiting;
  int hold_req = 0;
  int hold_served = 0;
  int sender_calm = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  paced_bit_change_queues_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .channel_index(channel_index), .push_level(push_level),
    .now_ms(now_ms), .rx_channel(rx_channel), .rx_value(rx_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .send_valid(send_valid), .send_word(send_word), .push_accepted(push_accepted),
    .rx_changed(rx_changed), .rx_levels(rx_levels),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pbcq_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .channel_index(channel_index), .push_level(push_level),
    .now_ms(now_ms), .rx_channel(rx_channel), .rx_value(rx_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .send_valid(send_valid), .send_word(send_word), .push_accepted(push_accepted),
    .rx_changed(rx_changed), .rx_levels(rx_levels),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .waiting(waiting)
  );

  // Receiver: random stall pattern, calm stretches, and one long hold-off on request.
  initial begin
    int pick;
    int span;
    forever begin
      @(negedge clk);
      if (hold_served != hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          out_stall <= 1'b0;
          span = $urandom_range(50, 150);
        end else if (pick < 50) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 4);
        end else if (pick < 92) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(10, 40);
        end
        repeat (span - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word was taken.
  task automatic send_item(pbcq_pkg::mode_t m, logic [CH_IDX_W-1:0] ch, logic lvl,
                           logic [TIME_W-1:0] now, logic [RX_CH_W-1:0] rxch,
                           logic [WORD_W-1:0] rxv);
    int pick;
    int gap;
    gap = 0;
    if (sender_calm > 0) begin
      sender_calm--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) sender_calm = $urandom_range(40, 120);
      if (pick >= 97) gap = $urandom_range(20, 60);
      else if (pick >= 90) gap = $urandom_range(4, 10);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    channel_index <= ch;
    push_level <= lvl;
    now_ms <= now;
    rx_channel <= rxch;
    rx_value <= rxv;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(pbcq_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [TIME_W-1:0] clock_ms;
    logic [CH_IDX_W-1:0] ch;
    logic [TIME_W-1:0] now;
    logic [RX_CH_W-1:0] rxch;
    pbcq_pkg::mode_t m;
    int step_max;
    int wild_pct;
    int pick;
    bit focus;

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, under reset register values (delay 100, empty mask).
    // Fields that a mode does not use are left at zero here.
    send_item(pbcq_pkg::MODE_PUSH, 4'd0, 1'b0, '0, '0, '0);   // equals output bit
    send_item(pbcq_pkg::MODE_PUSH, 4'd0, 1'b1, '0, '0, '0);
    send_item(pbcq_pkg::MODE_PUSH, 4'd0, 1'b1, '0, '0, '0);   // equals last queued
    send_item(pbcq_pkg::MODE_PUSH, 4'd15, 1'b1, '0, '0, '0);
    send_item(pbcq_pkg::MODE_TICK, '0, 1'b0, 32'd0, '0, '0);
    send_item(pbcq_pkg::MODE_TICK, '0, 1'b0, 32'd100, '0, '0);
    send_item(pbcq_pkg::MODE_TICK, '0, 1'b0, 32'd101, '0, '0);
    send_item(pbcq_pkg::MODE_TICK, '0, 1'b0, 32'd101, '0, '0);
    // Alternating levels fill the queue; the ninth push finds it full.
    for (int i = 0; i < 9; i++)
      send_item(pbcq_pkg::MODE_PUSH, 4'd0, i[0], '0, '0, '0);
    send_item(pbcq_pkg::MODE_CLEAR, '0, 1'b0, '0, '0, '0);
    send_item(pbcq_pkg::MODE_PUSH, 4'd0, 1'b1, '0, '0, '0);
    send_item(pbcq_pkg::MODE_RX, '0, 1'b0, '0, 8'd0, 16'hFFFF);
    send_item(pbcq_pkg::MODE_RX, '0, 1'b0, '0, 8'hFF, 16'h0000);
    send_item(pbcq_pkg::MODE_TICK, '0, 1'b0, 32'hFFFF_FFFF, '0, '0);
    send_item(pbcq_pkg::MODE_PUSH, 4'd7, 1'b1, '0, '0, '0);
    send_item(pbcq_pkg::MODE_TICK, '0, 1'b0, 32'hFFFF_FFFF, '0, '0);
    send_item(pbcq_pkg::MODE_RX, '0, 1'b0, '0, 8'd0, 16'h0000);

    clock_ms = 32'd200;
    for (int p = 0; p < PASSES; p++) begin
      drain();
      focus = 1'b0;
      wild_pct = 10;
      case (p)
        0: begin
          write_reg(pbcq_pkg::REG_RELEASE_DELAY, 32'd0);
          write_reg(pbcq_pkg::REG_LISTEN_MASK, 32'h0000_FFFF);
          step_max = 2;
        end
        1: begin
          write_reg(pbcq_pkg::REG_RELEASE_DELAY, 32'd5);
          write_reg(pbcq_pkg::REG_LISTEN_MASK, {16'd0, 16'($urandom)});
          step_max = 12;
          focus = 1'b1;
        end
        2: begin
          write_reg(pbcq_pkg::REG_RELEASE_DELAY, 32'd100);
          write_reg(pbcq_pkg::REG_LISTEN_MASK, 32'h0000_A5A5);
          step_max = 250;
          clock_ms = 32'hFFFF_FF00;   // time wraps during this pass
        end
        3: begin
          write_reg(pbcq_pkg::REG_RELEASE_DELAY, 32'hFFFF_FFFF);
          write_reg(pbcq_pkg::REG_LISTEN_MASK, 32'd0);
          step_max = 1000;
          focus = 1'b1;
          wild_pct = 60;
        end
        4: begin
          write_reg(pbcq_pkg::REG_RELEASE_DELAY, 32'h8000_0000);
          write_reg(pbcq_pkg::REG_LISTEN_MASK, 32'h0000_FFFF);
          step_max = 1000;
          wild_pct = 60;
        end
        default: begin
          write_reg(pbcq_pkg::REG_RELEASE_DELAY, $urandom_range(0, 30));
          write_reg(pbcq_pkg::REG_LISTEN_MASK, {16'd0, 16'($urandom)});
          step_max = 40;
        end
      endcase

      for (int i = 0; i < ITEMS_PER_PASS; i++) begin
        // Early in the first focused pass the receiver holds off while words keep coming.
        if (p == 1 && i == 30) begin
          hold_req++;
          sender_calm = 60;
        end
        pick = $urandom_range(0, 99);
        if (focus) begin
          if (pick < 70) m = pbcq_pkg::MODE_PUSH;
          else if (pick < 90) m = pbcq_pkg::MODE_TICK;
          else if (pick < 97) m = pbcq_pkg::MODE_RX;
          else m = pbcq_pkg::MODE_CLEAR;
        end else begin
          if (pick < 50) m = pbcq_pkg::MODE_PUSH;
          else if (pick < 83) m = pbcq_pkg::MODE_TICK;
          else if (pick < 98) m = pbcq_pkg::MODE_RX;
          else m = pbcq_pkg::MODE_CLEAR;
        end
        ch = (focus && $urandom_range(0, 4) != 0) ? CH_IDX_W'($urandom_range(0, 1))
                                                  : CH_IDX_W'($urandom);
        if ($urandom_range(0, 99) < wild_pct) begin
          now = $urandom;
        end else begin
          clock_ms = clock_ms + $urandom_range(0, step_max);
          now = clock_ms;
        end
        rxch = ($urandom_range(0, 9) == 0) ? RX_CH_W'($urandom_range(1, 255)) : '0;
        send_item(m, ch, 1'($urandom), now, rxch, WORD_W'($urandom));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### paced_bit_change_queues_core.f
design/pbcq_pkg.sv
design/pbcq_ctrl.sv
design/pbcq_datapath.sv
design/paced_bit_change_queues_core.sv
bench/pbcq_checker.sv
bench/tb_paced_bit_change_queues_core.sv
